>>> rtl/oofrb_pkg.sv
// Package for the out-of-order fill ring buffer.
// Item kinds, result status codes, slot state codes, sequencer states, defaults and a saturating increment.
// No dependencies.
package oofrb_pkg;

  localparam int DEF_ENTRIES = 256;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_TAKE  = 2'd0,
    KIND_READY = 2'd1,
    KIND_POP   = 2'd2,
    KIND_FREE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ALL_BUSY  = 2'd1,
    STAT_TAIL_BUSY = 2'd2,
    STAT_NO_READY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_BUSY  = 2'd1,
    SLOT_READY = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_ALLOC
  } seq_t;

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 32'd1;
  endfunction

endpackage

>>> rtl/oofrb_slot_ram.sv
// Slot state memory: one write port, one read port, registered read data.
// Standalone; used by out_of_order_fill_ring_buffer.
module oofrb_slot_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 2
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/out_of_order_fill_ring_buffer.sv
// Out-of-order fill ring buffer: ring of free/busy/ready slots with in-order retire.
// Depends on oofrb_pkg and oofrb_slot_ram.
//
//   channel  handshake             payload
//   req      req_valid/req_stall   kind, slot
//   rsp      rsp_valid/rsp_stall   status, slot_out, dropped_entries, dropped_takes
//
// An item first reads the tail slot from the state memory, then updates and gives its result.
// A take that overwrites the oldest entry also passes through SEQ_ALLOC: the memory's single write port
// frees the tail and then marks the head busy.
// After reset a clearing pass over all ENTRIES slots empties the memory; req is stalled.
// A result waiting on rsp_stall holds the item in its update cycle.
module out_of_order_fill_ring_buffer #(
  parameter int ENTRIES = oofrb_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  slot,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [7:0]  slot_out,
  output logic [31:0] dropped_entries,
  output logic [31:0] dropped_takes
);
  import oofrb_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  function automatic logic [IW-1:0] advance(input logic [IW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CW-1:0] inc_lim(input logic [CW-1:0] v);
    return (v < FULL) ? v + 1'b1 : FULL;
  endfunction

  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
    return (v != '0) ? v - 1'b1 : '0;
  endfunction

  seq_t          state, state_next;
  logic [IW-1:0] clr_addr, clr_addr_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [IW-1:0] alloc_addr, alloc_addr_next;
  logic [CW-1:0] ready_cnt, ready_cnt_next;
  logic [CW-1:0] busy_cnt, busy_cnt_next;
  logic [31:0]   drop_cnt, drop_cnt_next;
  logic [31:0]   rej_cnt, rej_cnt_next;
  kind_t         op_kind, op_kind_next;
  logic [7:0]    op_slot, op_slot_next;
  logic          rsp_valid_next;
  logic [1:0]    status_next;
  logic [7:0]    slot_out_next;
  logic [31:0]   dropped_entries_next;
  logic [31:0]   dropped_takes_next;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_state_t   wr_data;
  logic          rd_en;
  logic [1:0]    rd_data;

  logic [IW+7:0] mark_ext;
  logic [IW-1:0] mark_addr;
  logic          mark_ok;
  logic [IW+7:0] head_ext;
  logic [IW+7:0] tail_ext;
  logic          ring_full;
  logic          go;

  oofrb_slot_ram #(
    .DEPTH (ENTRIES),
    .AW    (IW),
    .DW    (2)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (tail),
    .rd_data (rd_data)
  );

  assign mark_ext  = (IW+8)'(op_slot);
  assign mark_addr = mark_ext[IW-1:0];
  assign mark_ok   = 32'(op_slot) < 32'(ENTRIES);
  assign head_ext  = (IW+8)'(head);
  assign tail_ext  = (IW+8)'(tail);
  assign ring_full = ((CW+1)'(busy_cnt) + (CW+1)'(ready_cnt)) == (CW+1)'(ENTRIES);
  assign go        = !rsp_valid || !rsp_stall;
  assign req_stall = (state != SEQ_IDLE);

  always_comb begin
    state_next           = state;
    clr_addr_next        = clr_addr;
    head_next            = head;
    tail_next            = tail;
    alloc_addr_next      = alloc_addr;
    ready_cnt_next       = ready_cnt;
    busy_cnt_next        = busy_cnt;
    drop_cnt_next        = drop_cnt;
    rej_cnt_next         = rej_cnt;
    op_kind_next         = op_kind;
    op_slot_next         = op_slot;
    rsp_valid_next       = rsp_valid;
    status_next          = status;
    slot_out_next        = slot_out;
    dropped_entries_next = dropped_entries;
    dropped_takes_next   = dropped_takes;
    wr_en                = 1'b0;
    wr_addr              = '0;
    wr_data              = SLOT_FREE;
    rd_en                = 1'b0;

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      SEQ_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST) begin
          state_next = SEQ_IDLE;
        end
      end
      SEQ_IDLE: begin
        if (req_valid) begin
          rd_en        = 1'b1;
          op_kind_next = kind_t'(kind);
          op_slot_next = slot;
          state_next   = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        if (go) begin
          rsp_valid_next       = 1'b1;
          status_next          = STAT_OK;
          slot_out_next        = '0;
          dropped_entries_next = '0;
          dropped_takes_next   = '0;
          state_next           = SEQ_IDLE;
          case (op_kind)
            KIND_TAKE: begin
              if (busy_cnt == FULL) begin
                drop_cnt_next = inc_sat32(drop_cnt);
                status_next   = STAT_ALL_BUSY;
              end else if (ring_full && rd_data == SLOT_BUSY) begin
                rej_cnt_next = inc_sat32(rej_cnt);
                status_next  = STAT_TAIL_BUSY;
              end else begin
                head_next     = advance(head);
                busy_cnt_next = inc_lim(busy_cnt);
                slot_out_next = head_ext[7:0];
                if (ring_full) begin
                  // overwrite oldest: free tail now, mark head busy next cycle
                  ready_cnt_next  = dec_sat(ready_cnt);
                  drop_cnt_next   = inc_sat32(drop_cnt);
                  tail_next       = advance(tail);
                  wr_en           = 1'b1;
                  wr_addr         = tail;
                  wr_data         = SLOT_FREE;
                  alloc_addr_next = head;
                  state_next      = SEQ_ALLOC;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = head;
                  wr_data = SLOT_BUSY;
                end
              end
            end
            KIND_READY: begin
              if (mark_ok) begin
                ready_cnt_next = inc_lim(ready_cnt);
                busy_cnt_next  = dec_sat(busy_cnt);
                wr_en          = 1'b1;
                wr_addr        = mark_addr;
                wr_data        = SLOT_READY;
              end
            end
            KIND_POP: begin
              if (rd_data == SLOT_READY) begin
                tail_next            = advance(tail);
                ready_cnt_next       = dec_sat(ready_cnt);
                busy_cnt_next        = inc_lim(busy_cnt);
                wr_en                = 1'b1;
                wr_addr              = tail;
                wr_data              = SLOT_BUSY;
                slot_out_next        = tail_ext[7:0];
                dropped_entries_next = drop_cnt;
                dropped_takes_next   = rej_cnt;
                drop_cnt_next        = '0;
                rej_cnt_next         = '0;
              end else begin
                status_next = STAT_NO_READY;
              end
            end
            KIND_FREE: begin
              if (mark_ok) begin
                busy_cnt_next = dec_sat(busy_cnt);
                wr_en         = 1'b1;
                wr_addr       = mark_addr;
                wr_data       = SLOT_FREE;
              end
            end
            default: begin
              status_next = STAT_OK;
            end
          endcase
        end
      end
      SEQ_ALLOC: begin
        wr_en      = 1'b1;
        wr_addr    = alloc_addr;
        wr_data    = SLOT_BUSY;
        state_next = SEQ_IDLE;
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_CLEAR;
      clr_addr  <= '0;
      head      <= '0;
      tail      <= '0;
      ready_cnt <= '0;
      busy_cnt  <= '0;
      drop_cnt  <= '0;
      rej_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      head      <= head_next;
      tail      <= tail_next;
      ready_cnt <= ready_cnt_next;
      busy_cnt  <= busy_cnt_next;
      drop_cnt  <= drop_cnt_next;
      rej_cnt   <= rej_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    alloc_addr      <= alloc_addr_next;
    op_kind         <= op_kind_next;
    op_slot         <= op_slot_next;
    status          <= status_next;
    slot_out        <= slot_out_next;
    dropped_entries <= dropped_entries_next;
    dropped_takes   <= dropped_takes_next;
  end

endmodule

>>> test/oofrb_checker.sv
// Checker for the out-of-order fill ring buffer: follows the ring from accepted request
// items and compares each accepted response item, field by field and in order.
// Depends on oofrb_pkg; reports its error count and outstanding responses to tb.
module oofrb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  slot,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  slot_out,
  input  logic [31:0] dropped_entries,
  input  logic [31:0] dropped_takes,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import oofrb_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot_no;
    logic [31:0] drops;
    logic [31:0] rejects;
  } ring_rsp_t;

  slot_state_t ring [ENTRIES];
  int unsigned head;
  int unsigned tail;
  int unsigned n_ready;
  int unsigned n_busy;
  logic [31:0] drop_cnt;
  logic [31:0] reject_cnt;
  ring_rsp_t   rsp_due_q [$];

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic int unsigned step_ptr(input int unsigned p);
    return (p + 1 >= ENTRIES) ? 0 : p + 1;
  endfunction

  task automatic flag(input string msg);
    if (errors < 50) $display("ring check: %s", msg);
    errors++;
  endtask

  task automatic apply_req(input kind_t k, input logic [7:0] s, output ring_rsp_t r);
    int unsigned at;
    r = '0;
    r.status = STAT_OK;
    case (k)
      KIND_TAKE: begin
        if (n_busy == ENTRIES) begin
          drop_cnt = bump32(drop_cnt);
          r.status = STAT_ALL_BUSY;
        end else if (n_busy + n_ready == ENTRIES && ring[tail] == SLOT_BUSY) begin
          reject_cnt = bump32(reject_cnt);
          r.status = STAT_TAIL_BUSY;
        end else begin
          // full with a ready oldest entry: it is overwritten
          if (n_busy + n_ready == ENTRIES) begin
            if (n_ready != 0) n_ready--;
            drop_cnt = bump32(drop_cnt);
            ring[tail] = SLOT_FREE;
            tail = step_ptr(tail);
          end
          at = head;
          head = step_ptr(head);
          if (n_busy < ENTRIES) n_busy++;
          ring[at] = SLOT_BUSY;
          r.slot_no = 8'(at);
        end
      end
      KIND_READY: begin
        if (s < ENTRIES) begin
          if (n_ready < ENTRIES) n_ready++;
          if (n_busy != 0) n_busy--;
          ring[s] = SLOT_READY;
        end
      end
      KIND_POP: begin
        if (ring[tail] == SLOT_READY) begin
          at = tail;
          tail = step_ptr(tail);
          if (n_ready != 0) n_ready--;
          if (n_busy < ENTRIES) n_busy++;
          ring[at] = SLOT_BUSY;
          r.slot_no = 8'(at);
          r.drops = drop_cnt;
          r.rejects = reject_cnt;
          drop_cnt = '0;
          reject_cnt = '0;
        end else begin
          r.status = STAT_NO_READY;
        end
      end
      KIND_FREE: begin
        if (s < ENTRIES) begin
          ring[s] = SLOT_FREE;
          if (n_busy != 0) n_busy--;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    ring_rsp_t want;
    ring_rsp_t seen;
    if (rst) begin
      foreach (ring[i]) ring[i] = SLOT_FREE;
      head = 0;
      tail = 0;
      n_ready = 0;
      n_busy = 0;
      drop_cnt = '0;
      reject_cnt = '0;
      rsp_due_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        seen.status = status_t'(status);
        seen.slot_no = slot_out;
        seen.drops = dropped_entries;
        seen.rejects = dropped_takes;
        if (rsp_due_q.size() == 0) begin
          flag($sformatf("response with none outstanding: status %0d slot %0d",
                         status, slot_out));
        end else begin
          want = rsp_due_q.pop_front();
          if (seen.status !== want.status)
            flag($sformatf("status %0d, predicted %0d", status, want.status));
          if (seen.slot_no !== want.slot_no)
            flag($sformatf("slot_out %0d, predicted %0d", slot_out, want.slot_no));
          if (seen.drops !== want.drops)
            flag($sformatf("dropped_entries %0d, predicted %0d", dropped_entries,
                           want.drops));
          if (seen.rejects !== want.rejects)
            flag($sformatf("dropped_takes %0d, predicted %0d", dropped_takes,
                           want.rejects));
        end
      end
      if (req_valid && !req_stall) begin
        apply_req(kind_t'(kind), slot, want);
        rsp_due_q.push_back(want);
      end
    end
    outstanding <= rsp_due_q.size();
  end

endmodule

>>> test/tb.sv
// Testbench top for the out-of-order fill ring buffer: makes request items in phases of
// sender idling and response stalling, and gives the verdict from the checker's count.
// Depends on oofrb_pkg, out_of_order_fill_ring_buffer and oofrb_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oofrb_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  kind;
  logic [7:0]  slot;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [1:0]  status;
  logic [7:0]  slot_out;
  logic [31:0] dropped_entries;
  logic [31:0] dropped_takes;
  int          errors;
  int          outstanding;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done;
  logic [7:0]  tail_guess = '0;
  kind_t       sent_kinds_q [$];
  logic [7:0]  granted_q [$];
  logic [7:0]  retired_q [$];

  out_of_order_fill_ring_buffer u_dut (.*);

  oofrb_checker u_chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // slots granted and retired, fed back to steer marks and pops
  always @(posedge clk) begin
    kind_t k;
    if (!rst && rsp_valid && !rsp_stall && sent_kinds_q.size() != 0) begin
      k = sent_kinds_q.pop_front();
      if (status == STAT_OK && k == KIND_TAKE) granted_q.push_back(slot_out);
      if (status == STAT_OK && k == KIND_POP) begin
        retired_q.push_back(slot_out);
        tail_guess <= slot_out + 8'd1;
      end
    end
    if (!rst && req_valid && !req_stall) sent_kinds_q.push_back(kind_t'(kind));
  end

  // response side: random stalls, and one long hold-off
  initial begin
    rsp_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        rsp_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(input kind_t k, input logic [7:0] s);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind <= k;
    slot <= s;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // take, mark ready (oldest few, out of order), pop, free what was retired, some noise
  task automatic lifecycle_items(input int count);
    int pick;
    int idx;
    logic [7:0] s;
    repeat (count) begin
      pick = $urandom_range(99);
      s = 8'($urandom);
      if (pick < 28) begin
        send_item(KIND_TAKE, s);
      end else if (pick < 52 && granted_q.size() != 0) begin
        idx = $urandom_range(granted_q.size() > 4 ? 3 : granted_q.size() - 1);
        s = granted_q[idx];
        granted_q.delete(idx);
        send_item(KIND_READY, s);
      end else if (pick < 76) begin
        send_item(KIND_POP, s);
      end else if (pick < 90 && retired_q.size() != 0) begin
        send_item(KIND_FREE, retired_q.pop_front());
      end else begin
        send_item(kind_t'($urandom_range(3)), s);
      end
    end
  endtask

  // fill to all busy, then full with tail busy, then overwrite the oldest, then pop
  task automatic fill_ring();
    int n;
    logic [7:0] t;
    t = tail_guess;
    repeat (256 + $urandom_range(2, 6)) send_item(KIND_TAKE, 8'($urandom));
    repeat (2) send_item(KIND_READY, t + 8'($urandom_range(64, 192)));
    repeat (3) send_item(KIND_TAKE, 8'($urandom));
    n = $urandom_range(4, 8);
    for (int j = 0; j < n; j++) send_item(KIND_READY, t + 8'(j));
    repeat (n + 2) send_item(KIND_TAKE, 8'($urandom));
    repeat (3) send_item(KIND_POP, 8'($urandom));
  endtask

  task automatic free_all();
    logic [7:0] s;
    s = 8'($urandom);
    repeat (256) begin
      send_item(KIND_FREE, s);
      s++;
    end
    granted_q.delete();
    retired_q.delete();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    kind = KIND_TAKE;
    slot = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_POP, 8'hFF);   // empty ring
    send_item(KIND_TAKE, 8'hFF);
    send_item(KIND_TAKE, 8'h00);
    send_item(KIND_POP, 8'h00);   // tail still busy
    send_item(KIND_READY, 8'd1);  // out of order
    send_item(KIND_POP, 8'h00);
    send_item(KIND_READY, 8'd0);
    send_item(KIND_POP, 8'h55);
    send_item(KIND_POP, 8'hAA);
    send_item(KIND_POP, 8'h00);   // tail slot free
    send_item(KIND_FREE, 8'd0);
    send_item(KIND_FREE, 8'd1);
    send_item(KIND_FREE, 8'hFF);  // busy count already at zero
    send_item(KIND_TAKE, 8'h00);
    send_item(KIND_READY, 8'd2);
    send_item(KIND_POP, 8'h00);
    send_item(KIND_FREE, 8'd2);
    drain();
    granted_q.delete();
    retired_q.delete();

    fill_ring();
    free_all();
    hold_go <= 1'b1;
    lifecycle_items(40);

    idle_pct = 87;
    lifecycle_items(120);

    idle_pct = 0;
    stall_pct <= 87;
    lifecycle_items(120);

    idle_pct = 21;
    stall_pct <= 21;
    lifecycle_items(60);
    fill_ring();

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
